// ===== rtl/i2cm_pkg.sv =====
package i2cm_pkg;

    localparam int S_TDATA_W       = 64;
    localparam int M_TDATA_W       = 24;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [9:0] OFS_ADDR   = 10'h280;
    localparam logic [9:0] OFS_DIV    = 10'h284;
    localparam logic [9:0] OFS_CTRL   = 10'h288;
    localparam logic [9:0] OFS_STATUS = 10'h28C;
    localparam logic [9:0] OFS_DATA   = 10'h290;

    localparam logic [5:0] SIZE_8  = 6'd8;
    localparam logic [5:0] SIZE_16 = 6'd16;
    localparam logic [5:0] SIZE_32 = 6'd32;

    localparam int CTRL_MASTER_BIT = 5;
    localparam int CTRL_TX_BIT     = 4;
    localparam int STATUS_IRQ_BIT  = 1;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_STOP  = 3'd4;

    localparam logic [2:0] SEL_ADDR   = 3'd0;
    localparam logic [2:0] SEL_DIV    = 3'd1;
    localparam logic [2:0] SEL_CTRL   = 3'd2;
    localparam logic [2:0] SEL_STATUS = 3'd3;
    localparam logic [2:0] SEL_DATA   = 3'd4;

    localparam logic [1:0] KIND_SIZE_ERR = 2'd0;
    localparam logic [1:0] KIND_UNMOD    = 2'd1;
    localparam logic [1:0] KIND_READ     = 2'd2;
    localparam logic [1:0] KIND_WRITE    = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] sel;
        logic [7:0] wbyte;
        logic       ack;
        logic [7:0] rbyte;
    } cmd_t;

    typedef struct packed {
        logic       dir_read;
        logic [7:0] tbyte;
        logic [2:0] op;
        logic       unmod;
        logic       status;
        logic [7:0] rdata;
    } result_t;

    typedef struct packed {
        logic busy;
        logic master;
        logic addr_phase;
    } ctl_state_t;

endpackage

// ===== rtl/i2cm_front.sv =====
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    input  logic                 queue_full,
    output logic                 push,
    output cmd_t                 cmd
);

    logic [9:0] reg_offset;
    logic [5:0] access_size;
    logic       is_reg;
    logic       size_legal;
    logic [2:0] sel;

    assign reg_offset  = s_axis_tdata[9:0];
    assign access_size = s_axis_tdata[15:10];

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    always_comb begin
        is_reg = 1'b1;
        sel    = SEL_ADDR;
        unique case (reg_offset)
            OFS_ADDR:   sel = SEL_ADDR;
            OFS_DIV:    sel = SEL_DIV;
            OFS_CTRL:   sel = SEL_CTRL;
            OFS_STATUS: sel = SEL_STATUS;
            OFS_DATA:   sel = SEL_DATA;
            default:    is_reg = 1'b0;
        endcase
    end

    assign size_legal = (access_size == SIZE_8) || (access_size == SIZE_16) ||
                        (access_size == SIZE_32);

    always_comb begin
        cmd.sel   = sel;
        cmd.wbyte = s_axis_tdata[23:16];
        cmd.ack   = s_axis_tdata[48];
        cmd.rbyte = s_axis_tdata[56:49];
        if (!size_legal) begin
            cmd.kind = KIND_SIZE_ERR;
        end else if (!is_reg) begin
            cmd.kind = KIND_UNMOD;
        end else if (access_size != SIZE_8) begin
            cmd.kind = KIND_SIZE_ERR;
        end else if (s_axis_tuser) begin
            cmd.kind = KIND_WRITE;
        end else begin
            cmd.kind = KIND_READ;
        end
    end

endmodule

// ===== rtl/i2cm_queue.sv =====
module i2cm_queue
    import i2cm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/i2cm_back.sv =====
module i2cm_back
    import i2cm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    input  cmd_t                 cmd,
    output logic                 pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output ctl_state_t           ctl_state
);

    logic [7:0] address_reg;
    logic [7:0] address_next;
    logic [7:0] divider_reg;
    logic [7:0] divider_next;
    logic [7:0] control_reg;
    logic [7:0] control_next;
    logic       busy_reg;
    logic       busy_next;
    logic       irq_reg;
    logic       irq_next;
    logic       nack_reg;
    logic       nack_next;
    logic       addr_phase_reg;
    logic       addr_phase_next;
    logic [7:0] rx_byte_reg;
    logic [7:0] rx_byte_next;
    result_t    result_reg;
    result_t    result_next;
    logic       out_valid_reg;
    logic       was_master;
    logic       now_master;

    assign pop        = cmd_valid && (!out_valid_reg || m_axis_tready);
    assign was_master = control_reg[CTRL_MASTER_BIT];
    assign now_master = cmd.wbyte[CTRL_MASTER_BIT];

    always_comb begin
        address_next    = address_reg;
        divider_next    = divider_reg;
        control_next    = control_reg;
        busy_next       = busy_reg;
        irq_next        = irq_reg;
        nack_next       = nack_reg;
        addr_phase_next = addr_phase_reg;
        rx_byte_next    = rx_byte_reg;
        result_next     = '0;
        result_next.op  = OP_NONE;
        unique case (cmd.kind)
            KIND_SIZE_ERR: result_next.status = 1'b1;
            KIND_UNMOD:    result_next.unmod = 1'b1;
            KIND_READ: begin
                unique case (cmd.sel)
                    SEL_ADDR:   result_next.rdata = address_reg;
                    SEL_DIV:    result_next.rdata = divider_reg;
                    SEL_CTRL:   result_next.rdata = control_reg;
                    SEL_STATUS: result_next.rdata = {2'b00, busy_reg, 3'b000, irq_reg, nack_reg};
                    SEL_DATA: begin
                        result_next.rdata = rx_byte_reg;
                        if (was_master && !control_reg[CTRL_TX_BIT]) begin
                            rx_byte_next   = cmd.rbyte;
                            irq_next       = 1'b1;
                            result_next.op = OP_READ;
                        end
                    end
                    default: result_next.rdata = '0;
                endcase
            end
            KIND_WRITE: begin
                unique case (cmd.sel)
                    SEL_ADDR: address_next = cmd.wbyte;
                    SEL_DIV:  divider_next = cmd.wbyte;
                    SEL_CTRL: begin
                        control_next = cmd.wbyte;
                        if (!was_master && now_master) begin
                            busy_next       = 1'b1;
                            addr_phase_next = 1'b1;
                        end else if (was_master && !now_master) begin
                            busy_next       = 1'b0;
                            addr_phase_next = 1'b0;
                            result_next.op  = OP_STOP;
                        end
                    end
                    SEL_STATUS: begin
                        if (!cmd.wbyte[STATUS_IRQ_BIT]) begin
                            irq_next = 1'b0;
                        end
                    end
                    SEL_DATA: begin
                        if (was_master) begin
                            if (addr_phase_reg) begin
                                addr_phase_next      = 1'b0;
                                result_next.op       = OP_START;
                                result_next.tbyte    = {1'b0, cmd.wbyte[7:1]};
                                result_next.dir_read = cmd.wbyte[0];
                            end else begin
                                result_next.op    = OP_WRITE;
                                result_next.tbyte = cmd.wbyte;
                            end
                            nack_next = !cmd.ack;
                            irq_next  = 1'b1;
                        end
                    end
                    default: result_next.op = OP_NONE;
                endcase
            end
            default: result_next.status = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            address_reg    <= '0;
            divider_reg    <= '0;
            control_reg    <= '0;
            busy_reg       <= 1'b0;
            irq_reg        <= 1'b0;
            nack_reg       <= 1'b0;
            addr_phase_reg <= 1'b0;
            rx_byte_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                address_reg    <= address_next;
                divider_reg    <= divider_next;
                control_reg    <= control_next;
                busy_reg       <= busy_next;
                irq_reg        <= irq_next;
                nack_reg       <= nack_next;
                addr_phase_reg <= addr_phase_next;
                rx_byte_reg    <= rx_byte_next;
                out_valid_reg  <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(result_reg);

    assign ctl_state.busy       = busy_reg;
    assign ctl_state.master     = was_master;
    assign ctl_state.addr_phase = addr_phase_reg;

endmodule

// ===== rtl/i2c_master_bus_controller.sv =====
// I2C master controller register window, one processor bus access per word.
// Slave side: s_axis_tuser is the access direction (1 write, 0 read);
// s_axis_tdata carries offset, size, write value and the target's response.
// Master side: one result word per accepted access, in order: read value,
// bus status, unmodelled flag and the bus operation issued to the target.
// Accesses are decoded on entry and queued (QUEUE_DEPTH words); the register
// stage behind the queue applies them one per cycle while the output is not
// stalled and holds the result in an output register.
// An accepted access is held in the queue and then in the output register.
// Throughput: one word per cycle while m_axis_tready stays high.
// When the receiver stalls, the result holds and the queue absorbs up to
// QUEUE_DEPTH more words; s_axis_tready drops once it is full.
// Reset (aresetn low, synchronous) clears all window registers, status flags, the
// queue and the output valid.
module i2c_master_bus_controller
    import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [9:0] reg_offset, [15:10] access_size, [47:16] write_data,
    // [48] target_ack, [56:49] target_read_byte, [63:57] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] func
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] read_data, [8] bus_status, [9] unmodelled, [12:10] target_op,
    // [20:13] target_byte, [21] target_dir_read, [23:22] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic       push;
    logic       queue_full;
    cmd_t       push_cmd;
    logic       pop;
    logic       queue_valid;
    cmd_t       pop_cmd;
    ctl_state_t ctl_state;

    i2cm_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push),
        .cmd           (push_cmd)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .valid     (queue_valid),
        .pop_data  (pop_cmd)
    );

    i2cm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (queue_valid),
        .cmd           (pop_cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .ctl_state     (ctl_state)
    );

    a_busy_tracks_master: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_state.busy == ctl_state.master)
        else $error("busy flag out of step with master bit");

    a_addr_phase_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_state.addr_phase |-> ctl_state.busy)
        else $error("address phase open while bus idle");

    a_reset_no_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule
